FILE: hdl/qpfld_pkg.sv
// shared types and constants for the qpack field line decoder
package qpfld_pkg;

  localparam int unsigned STATIC_ENTRIES = 63;
  localparam int unsigned LENGTH_BITS    = 32;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned SHIFT_W        = 7;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned GROUP_W        = 7;
  localparam int unsigned SHIFT_STEP     = 7;
  localparam int unsigned SHIFT_MAX      = 63;

  localparam logic [ACC_W-1:0] LEN_LIMIT = ACC_W'({LENGTH_BITS{1'b1}});

  typedef enum logic [1:0] {
    EV_PREFIX = 2'd0,
    EV_NAME   = 2'd1,
    EV_VALUE  = 2'd2,
    EV_ERROR  = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    KIND_INDEXED = 2'd0,
    KIND_NAMEREF = 2'd1,
    KIND_LITERAL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_UNSUPPORTED = 3'd1,
    ERR_INDEX       = 3'd2,
    ERR_TRUNCATED   = 3'd3,
    ERR_OVERFLOW    = 3'd4
  } err_e;

  typedef struct packed {
    event_e           ev;
    kind_e            kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       dout;
    logic             done;
    logic             ok;
    err_e             code;
  } res_t;

endpackage

FILE: hdl/qpack_field_line_decoder_core.sv
// top level: input register, byte parser and result register
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | data_byte_i, block_end_i
//  out     | out_valid_o/out_ready_i | event_res_o, line_kind_o, static_index_o,
//          |                         | data_out_o, line_done_o, block_ok_o,
//          |                         | error_code_o
//
// one byte per cycle sustained while out_ready_i is high
// each byte is parsed in one pass between the input register and result register
// one result per byte; parse state returns to its reset value after a block end byte
// a stalled result holds the byte behind it; in_ready_o then follows out_ready_i
// rst_ni clears the parse state and both valid flags
module qpack_field_line_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       block_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_res_o,
  output logic [1:0] line_kind_o,
  output logic [5:0] static_index_o,
  output logic [7:0] data_out_o,
  output logic       line_done_o,
  output logic       block_ok_o,
  output logic [2:0] error_code_o
);

  logic            in_vld_q;
  logic [7:0]      data_q;
  logic            end_q;
  logic            out_vld_q;
  qpfld_pkg::res_t res;
  qpfld_pkg::res_t out_q;
  logic            advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_byte_i;
      end_q  <= block_end_i;
    end
  end

  qpfld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (data_q),
    .block_end_i (end_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_res_o    = out_q.ev;
  assign line_kind_o    = out_q.kind;
  assign static_index_o = out_q.idx;
  assign data_out_o     = out_q.dout;
  assign line_done_o    = out_q.done;
  assign block_ok_o     = out_q.ok;
  assign error_code_o   = out_q.code;

  a_error_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.ev == qpfld_pkg::EV_ERROR |-> out_q.code != qpfld_pkg::ERR_NONE)
    else $error("error item without code");

  a_ok_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.ok |-> out_q.ev != qpfld_pkg::EV_ERROR
      && out_q.code == qpfld_pkg::ERR_NONE)
    else $error("block ok together with error");

  a_pending_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(data_q) && $stable(end_q))
    else $error("pending input byte lost");

endmodule

FILE: hdl/qpfld_varint.sv
// continuation group add for prefixed integers with 64-bit overflow detection
module qpfld_varint (
  input  logic [qpfld_pkg::ACC_W-1:0]   acc_i,
  input  logic [qpfld_pkg::SHIFT_W-1:0] shift_i,
  input  logic [qpfld_pkg::GROUP_W-1:0] group_i,
  output logic [qpfld_pkg::ACC_W-1:0]   sum_o,
  output logic                          ovf_o
);

  localparam int unsigned WIDE_W = qpfld_pkg::ACC_W + qpfld_pkg::GROUP_W;

  logic [WIDE_W-1:0] term;
  logic [WIDE_W-1:0] wide;

  assign term  = {{qpfld_pkg::ACC_W{1'b0}}, group_i} << shift_i;
  assign wide  = {{qpfld_pkg::GROUP_W{1'b0}}, acc_i} + term;
  assign sum_o = wide[qpfld_pkg::ACC_W-1:0];
  assign ovf_o = |wide[WIDE_W-1:qpfld_pkg::ACC_W];

endmodule

FILE: hdl/qpfld_parser.sv
// parse state and single-pass next-state and result logic for one byte
module qpfld_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       data_byte_i,
  input  logic             block_end_i,
  output qpfld_pkg::res_t  res_o
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_INDEX   = 3'd1;
  localparam logic [2:0] PH_NAMELEN = 3'd2;
  localparam logic [2:0] PH_NAME    = 3'd3;
  localparam logic [2:0] PH_VALLEN0 = 3'd4;
  localparam logic [2:0] PH_VALLEN  = 3'd5;
  localparam logic [2:0] PH_VALUE   = 3'd6;
  localparam logic [2:0] PH_SKIP    = 3'd7;

  logic [2:0]                        phase_q, phase_d;
  qpfld_pkg::kind_e                  kind_q, kind_d;
  logic [qpfld_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic [qpfld_pkg::SHIFT_W-1:0]     shift_q, shift_d;
  logic [qpfld_pkg::LENGTH_BITS-1:0] left_q, left_d;
  logic [qpfld_pkg::IDX_W-1:0]       idx_q, idx_d;
  qpfld_pkg::err_e                   err_q, err_d;

  logic [qpfld_pkg::ACC_W-1:0]   vi_sum;
  logic                          vi_ovf;
  logic [qpfld_pkg::SHIFT_W-1:0] shift_sum;

  logic                          int_done;
  logic                          int_start;
  logic                          prefix_max;
  logic [6:0]                    prefix;
  logic [2:0]                    which;
  logic [qpfld_pkg::ACC_W-1:0]   acc_val;
  logic                          fin;
  qpfld_pkg::err_e               err_fin;
  qpfld_pkg::res_t               res;

  qpfld_varint u_varint (
    .acc_i   (acc_q),
    .shift_i (shift_q),
    .group_i (data_byte_i[6:0]),
    .sum_o   (vi_sum),
    .ovf_o   (vi_ovf)
  );

  assign shift_sum = shift_q + qpfld_pkg::SHIFT_W'(qpfld_pkg::SHIFT_STEP);

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    acc_d      = acc_q;
    shift_d    = shift_q;
    left_d     = left_q;
    idx_d      = idx_q;
    err_d      = err_q;
    int_done   = 1'b0;
    int_start  = 1'b0;
    prefix_max = 1'b0;
    prefix     = '0;
    which      = phase_q;
    acc_val    = vi_sum;
    fin        = 1'b0;
    err_fin    = qpfld_pkg::ERR_NONE;
    res        = '0;
    res.ev     = qpfld_pkg::EV_PREFIX;

    unique case (phase_q)
      PH_FIRST: begin
        if (data_byte_i[7]) begin
          kind_d     = qpfld_pkg::KIND_INDEXED;
          which      = PH_INDEX;
          prefix     = {1'b0, data_byte_i[5:0]};
          prefix_max = &data_byte_i[5:0];
          int_start  = 1'b1;
        end else if (data_byte_i[6]) begin
          kind_d     = qpfld_pkg::KIND_NAMEREF;
          which      = PH_INDEX;
          prefix     = {1'b0, data_byte_i[5:0]};
          prefix_max = &data_byte_i[5:0];
          int_start  = 1'b1;
        end else if (data_byte_i[5]) begin
          kind_d     = qpfld_pkg::KIND_LITERAL;
          which      = PH_NAMELEN;
          prefix     = {2'b00, data_byte_i[4:0]};
          prefix_max = &data_byte_i[4:0];
          int_start  = 1'b1;
        end else begin
          err_d   = qpfld_pkg::ERR_UNSUPPORTED;
          phase_d = PH_SKIP;
        end
      end
      PH_INDEX, PH_NAMELEN, PH_VALLEN: begin
        if (vi_ovf) begin
          err_d   = qpfld_pkg::ERR_OVERFLOW;
          phase_d = PH_SKIP;
        end else if (data_byte_i[7]) begin
          acc_d   = vi_sum;
          shift_d = shift_sum;
          if (shift_sum > qpfld_pkg::SHIFT_W'(qpfld_pkg::SHIFT_MAX)) begin
            err_d   = qpfld_pkg::ERR_OVERFLOW;
            phase_d = PH_SKIP;
          end else if (phase_q != PH_INDEX && vi_sum > qpfld_pkg::LEN_LIMIT) begin
            err_d   = qpfld_pkg::ERR_OVERFLOW;
            phase_d = PH_SKIP;
          end
        end else begin
          acc_d    = vi_sum;
          int_done = 1'b1;
        end
      end
      PH_VALLEN0: begin
        which      = PH_VALLEN;
        prefix     = data_byte_i[6:0];
        prefix_max = &data_byte_i[6:0];
        int_start  = 1'b1;
      end
      PH_NAME: begin
        res.ev   = qpfld_pkg::EV_NAME;
        res.dout = data_byte_i;
        left_d   = left_q - qpfld_pkg::LENGTH_BITS'(1);
        if (left_q == qpfld_pkg::LENGTH_BITS'(1)) begin
          phase_d = PH_VALLEN0;
        end
      end
      PH_VALUE: begin
        res.ev   = qpfld_pkg::EV_VALUE;
        res.dout = data_byte_i;
        left_d   = left_q - qpfld_pkg::LENGTH_BITS'(1);
        if (left_q == qpfld_pkg::LENGTH_BITS'(1)) begin
          fin     = 1'b1;
          phase_d = PH_FIRST;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    if (int_start) begin
      acc_d   = qpfld_pkg::ACC_W'(prefix);
      acc_val = qpfld_pkg::ACC_W'(prefix);
      shift_d = '0;
      if (prefix_max) begin
        phase_d = which;
      end else begin
        int_done = 1'b1;
      end
    end

    if (int_done) begin
      if (which == PH_INDEX) begin
        if (acc_val >= qpfld_pkg::ACC_W'(qpfld_pkg::STATIC_ENTRIES)) begin
          err_d   = qpfld_pkg::ERR_INDEX;
          phase_d = PH_SKIP;
        end else begin
          idx_d = acc_val[qpfld_pkg::IDX_W-1:0];
          if (kind_d == qpfld_pkg::KIND_INDEXED) begin
            fin     = 1'b1;
            phase_d = PH_FIRST;
          end else begin
            phase_d = PH_VALLEN0;
          end
        end
      end else if (acc_val > qpfld_pkg::LEN_LIMIT) begin
        err_d   = qpfld_pkg::ERR_OVERFLOW;
        phase_d = PH_SKIP;
      end else if (acc_val == '0) begin
        if (which == PH_NAMELEN) begin
          phase_d = PH_VALLEN0;
        end else begin
          fin     = 1'b1;
          phase_d = PH_FIRST;
        end
      end else begin
        left_d  = acc_val[qpfld_pkg::LENGTH_BITS-1:0];
        phase_d = (which == PH_NAMELEN) ? PH_NAME : PH_VALUE;
      end
    end

    res.kind = kind_d;
    res.done = fin;
    if (fin && kind_d != qpfld_pkg::KIND_LITERAL) begin
      res.idx = idx_d;
    end

    err_fin = err_d;
    if (block_end_i && err_d == qpfld_pkg::ERR_NONE && phase_d != PH_FIRST) begin
      err_fin = qpfld_pkg::ERR_TRUNCATED;
    end
    err_d = err_fin;

    if (err_fin != qpfld_pkg::ERR_NONE) begin
      res.ev   = qpfld_pkg::EV_ERROR;
      res.code = err_fin;
      res.kind = qpfld_pkg::KIND_INDEXED;
      res.idx  = '0;
      res.dout = '0;
      res.done = 1'b0;
    end else if (block_end_i) begin
      res.ok = 1'b1;
    end

    if (block_end_i) begin
      phase_d = PH_FIRST;
      kind_d  = qpfld_pkg::KIND_INDEXED;
      acc_d   = '0;
      shift_d = '0;
      left_d  = '0;
      idx_d   = '0;
      err_d   = qpfld_pkg::ERR_NONE;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      kind_q  <= qpfld_pkg::KIND_INDEXED;
      acc_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      idx_q   <= '0;
      err_q   <= qpfld_pkg::ERR_NONE;
    end else if (advance_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
    end
  end

  a_skip_iff_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) == (err_q != qpfld_pkg::ERR_NONE))
    else $error("skip phase and held error disagree");

  a_block_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && block_end_i |=> phase_q == PH_FIRST && err_q == qpfld_pkg::ERR_NONE)
    else $error("parser not reset after block end");

  a_string_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NAME || phase_q == PH_VALUE) |-> left_q != '0)
    else $error("string phase with no bytes left");

endmodule

FILE: test/qpack_field_line_decoder_core_tb.sv
// testbench for qpack_field_line_decoder_core: directed and random header blocks checked per byte
`timescale 1ns / 1ps

module qpack_field_line_decoder_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_INDEX,
    PH_NAMELEN,
    PH_NAME,
    PH_VALLEN0,
    PH_VALLEN,
    PH_VALUE,
    PH_SKIP
  } parse_phase_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'd0;
  logic       block_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [1:0] event_res;
  logic [1:0] line_kind;
  logic [5:0] static_index;
  logic [7:0] data_out;
  logic       line_done;
  logic       block_ok;
  logic [2:0] error_code;

  // parser state mirrored in the testbench
  parse_phase_e                parse_ph;
  qpfld_pkg::kind_e            kind_q;
  logic [63:0]                 acc_val;
  logic [6:0]                  acc_shift;
  logic [63:0]                 str_remaining;
  logic [qpfld_pkg::IDX_W-1:0] index_q;
  qpfld_pkg::err_e             err_q;
  logic                        line_complete;

  qpfld_pkg::res_t decoded_q[$];
  qpfld_pkg::res_t want_r;
  logic [7:0]      block_bytes[$];
  int              counted_items = 0;
  int              errors = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic            idle_on = 1'b1;

  qpack_field_line_decoder_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .block_end_i    (block_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_res_o    (event_res),
    .line_kind_o    (line_kind),
    .static_index_o (static_index),
    .data_out_o     (data_out),
    .line_done_o    (line_done),
    .block_ok_o     (block_ok),
    .error_code_o   (error_code)
  );

  always #2 clk = ~clk;

  function automatic void append_byte(logic [7:0] b);
    block_bytes.insert(block_bytes.size(), b);
  endfunction

  function automatic void reset_parser();
    parse_ph      = PH_FIRST;
    kind_q        = qpfld_pkg::KIND_INDEXED;
    acc_val       = '0;
    acc_shift     = '0;
    str_remaining = '0;
    index_q       = '0;
    err_q         = qpfld_pkg::ERR_NONE;
    line_complete = 1'b0;
  endfunction

  function automatic void raise_error(qpfld_pkg::err_e code);
    err_q    = code;
    parse_ph = PH_SKIP;
  endfunction

  function automatic void finish_int(parse_phase_e which);
    if (which == PH_INDEX) begin
      if (acc_val >= 64'(qpfld_pkg::STATIC_ENTRIES)) begin
        raise_error(qpfld_pkg::ERR_INDEX);
        return;
      end
      index_q = acc_val[qpfld_pkg::IDX_W-1:0];
      if (kind_q == qpfld_pkg::KIND_INDEXED) begin
        line_complete = 1'b1;
        parse_ph = PH_FIRST;
      end else begin
        parse_ph = PH_VALLEN0;
      end
      return;
    end
    if (acc_val > qpfld_pkg::LEN_LIMIT) begin
      raise_error(qpfld_pkg::ERR_OVERFLOW);
    end else if (acc_val == 0) begin
      if (which == PH_NAMELEN) begin
        parse_ph = PH_VALLEN0;
      end else begin
        line_complete = 1'b1;
        parse_ph = PH_FIRST;
      end
    end else begin
      str_remaining = acc_val;
      parse_ph = (which == PH_NAMELEN) ? PH_NAME : PH_VALUE;
    end
  endfunction

  function automatic void start_int(logic [7:0] prefix, logic [7:0] max_prefix,
                                    parse_phase_e which);
    acc_val   = {56'd0, prefix};
    acc_shift = '0;
    if (prefix < max_prefix) begin
      finish_int(which);
    end else begin
      parse_ph = which;
    end
  endfunction

  function automatic logic add_group(logic [7:0] b);
    logic [63:0] grp;
    logic [63:0] term;
    grp = {57'd0, b[6:0]};
    if (acc_shift >= 64) return 1'b0;
    if (acc_shift > 0 && (grp >> (64 - int'(acc_shift))) != 0) return 1'b0;
    term = grp << acc_shift;
    if (acc_val > (64'hffff_ffff_ffff_ffff - term)) return 1'b0;
    acc_val = acc_val + term;
    return 1'b1;
  endfunction

  function automatic void continue_int(logic [7:0] b);
    parse_phase_e which;
    which = parse_ph;
    if (!add_group(b)) begin
      raise_error(qpfld_pkg::ERR_OVERFLOW);
      return;
    end
    if (b[7]) begin
      acc_shift = acc_shift + 7'(qpfld_pkg::SHIFT_STEP);
      if (acc_shift > 7'(qpfld_pkg::SHIFT_MAX)) begin
        raise_error(qpfld_pkg::ERR_OVERFLOW);
      end else if (which != PH_INDEX && acc_val > qpfld_pkg::LEN_LIMIT) begin
        raise_error(qpfld_pkg::ERR_OVERFLOW);
      end
    end else begin
      finish_int(which);
    end
  endfunction

  // expected result of one accepted byte
  function automatic void decode_byte(logic [7:0] b, logic is_last);
    qpfld_pkg::res_t r;
    r = '0;
    line_complete = 1'b0;
    counted_items++;
    case (parse_ph)
      PH_FIRST: begin
        if (b[7]) begin
          kind_q = qpfld_pkg::KIND_INDEXED;
          start_int({2'b0, b[5:0]}, 8'h3f, PH_INDEX);
        end else if (b[6]) begin
          kind_q = qpfld_pkg::KIND_NAMEREF;
          start_int({2'b0, b[5:0]}, 8'h3f, PH_INDEX);
        end else if (b[5]) begin
          kind_q = qpfld_pkg::KIND_LITERAL;
          start_int({3'b0, b[4:0]}, 8'h1f, PH_NAMELEN);
        end else begin
          raise_error(qpfld_pkg::ERR_UNSUPPORTED);
        end
      end
      PH_INDEX, PH_NAMELEN, PH_VALLEN: begin
        continue_int(b);
      end
      PH_VALLEN0: begin
        start_int({1'b0, b[6:0]}, 8'h7f, PH_VALLEN);
      end
      PH_NAME: begin
        r.ev = qpfld_pkg::EV_NAME;
        r.dout = b;
        str_remaining = str_remaining - 64'd1;
        if (str_remaining == 0) parse_ph = PH_VALLEN0;
      end
      PH_VALUE: begin
        r.ev = qpfld_pkg::EV_VALUE;
        r.dout = b;
        str_remaining = str_remaining - 64'd1;
        if (str_remaining == 0) begin
          line_complete = 1'b1;
          parse_ph = PH_FIRST;
        end
      end
      default: ;
    endcase
    r.kind = kind_q;
    r.done = line_complete;
    if (line_complete && kind_q != qpfld_pkg::KIND_LITERAL) r.idx = index_q;
    if (is_last && err_q == qpfld_pkg::ERR_NONE && parse_ph != PH_FIRST) begin
      err_q = qpfld_pkg::ERR_TRUNCATED;
    end
    if (err_q != qpfld_pkg::ERR_NONE) begin
      r.ev   = qpfld_pkg::EV_ERROR;
      r.code = err_q;
      r.kind = qpfld_pkg::KIND_INDEXED;
      r.idx  = '0;
      r.dout = '0;
      r.done = 1'b0;
    end else if (is_last) begin
      r.ok = 1'b1;
    end
    decoded_q.insert(decoded_q.size(), r);
    if (is_last) reset_parser();
  endfunction

  // prefixed integer encoding
  function automatic void push_int(logic [63:0] v, int unsigned pbits, logic [7:0] flags);
    logic [63:0] lim;
    lim = (64'd1 << pbits) - 64'd1;
    if (v < lim) begin
      append_byte(flags | v[7:0]);
      return;
    end
    append_byte(flags | lim[7:0]);
    v = v - lim;
    while (v >= 128) begin
      append_byte({1'b1, v[6:0]});
      v = v >> 7;
    end
    // redundant zero groups now and then
    if ($urandom_range(0, 7) == 0) begin
      append_byte({1'b1, v[6:0]});
      repeat ($urandom_range(0, 2)) append_byte(8'h80);
      append_byte(8'h00);
    end else begin
      append_byte({1'b0, v[6:0]});
    end
  endfunction

  function automatic void push_value();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = (r < 80) ? $urandom_range(0, 5) : (r < 97) ? $urandom_range(6, 20) :
        $urandom_range(120, 135);
    push_int(64'(n), 7, {1'($urandom_range(0, 1)), 7'd0});
    repeat (n) append_byte(8'($urandom));
  endfunction

  function automatic void push_line();
    int unsigned sel;
    int unsigned n;
    logic [63:0] idx;
    sel = $urandom_range(0, 99);
    idx = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(63, 400)) :
          64'($urandom_range(0, 62));
    if (sel < 30) begin
      push_int(idx, 6, {1'b1, 1'($urandom_range(0, 1)), 6'd0});
    end else if (sel < 60) begin
      push_int(idx, 6, 8'h40);
      push_value();
    end else if (sel < 90) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 5);
      push_int(64'(n), 5, 8'h20);
      repeat (n) append_byte(8'($urandom));
      push_value();
    end else if (sel < 95) begin
      append_byte(8'($urandom_range(0, 31)));
    end else begin
      // long continuation chain on an index or a length
      case ($urandom_range(0, 2))
        0:       append_byte(8'hbf);
        1:       append_byte(8'h7f);
        default: append_byte(8'h3f);
      endcase
      repeat ($urandom_range(3, 11)) append_byte({1'b1, 7'($urandom)});
      append_byte({1'b0, 7'($urandom)});
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    block_end <= is_last;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, is_last);
  endtask

  task automatic send_block();
    for (int i = 0; i < block_bytes.size(); i++) begin
      send_byte(block_bytes[i], i == block_bytes.size() - 1);
    end
    block_bytes.delete();
  endtask

  task automatic test_indexed_lines();
    block_bytes = '{8'h80, 8'hbe};
    send_block();
  endtask

  task automatic test_name_reference();
    block_bytes = '{8'h45, 8'h81, 8'h61};
    send_block();
  endtask

  task automatic test_literal_name();
    // second line has zero name and value lengths
    block_bytes = '{8'h21, 8'h78, 8'h01, 8'h79, 8'h20, 8'h00};
    send_block();
  endtask

  task automatic test_unsupported();
    block_bytes = '{8'h00, 8'hff};
    send_block();
  endtask

  task automatic test_index_range();
    block_bytes = '{8'h7f, 8'h00, 8'h42};
    send_block();
  endtask

  task automatic test_truncated_block();
    block_bytes = '{8'h45};
    send_block();
  endtask

  task automatic test_length_overflow();
    block_bytes = '{8'h3f, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f};
    send_block();
  endtask

  task automatic test_random_blocks(input int target);
    int unsigned r;
    int unsigned cut;
    while (counted_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        repeat ($urandom_range(1, 4)) push_line();
        if (r >= 78) begin
          cut = $urandom_range(1, block_bytes.size());
          block_bytes = block_bytes[0:cut-1];
        end
      end else begin
        repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
      end
      send_block();
    end
  endtask

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    out_ready <= !idle_on || stall_left == 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got event_res %0d", $time, event_res);
        errors++;
      end else begin
        want_r = decoded_q.pop_front();
        compare_field("event_res", want_r.ev, event_res);
        compare_field("line_kind", want_r.kind, line_kind);
        compare_field("static_index", want_r.idx, static_index);
        compare_field("data_out", want_r.dout, data_out);
        compare_field("line_done", want_r.done, line_done);
        compare_field("block_ok", want_r.ok, block_ok);
        compare_field("error_code", want_r.code, error_code);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (in_valid || decoded_q.size() != 0) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    reset_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_indexed_lines();
    test_name_reference();
    test_literal_name();
    test_unsupported();
    test_index_range();
    test_truncated_block();
    test_length_overflow();
    test_random_blocks(1500);
    idle_on = 1'b0;
    test_random_blocks(1750);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
